@@ sv/assert_macros.svh @@
// Assertion macros shared by the frame rotate / mirror RTL.
// Needs nothing else; the checks fall away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ sv/frm_pkg.sv @@
// Shared types and constants of the frame rotate / mirror block.
// No dependencies; every other file but assert_macros.svh imports this package.
package frm_pkg;

	localparam int MAX_SIDE_DEF = 64;

	localparam int MODE_W     = 3;
	localparam int DIM_REG_W  = 7;
	localparam int PIX_W      = 8;
	localparam int COORD_W    = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [DIM_REG_W-1:0] ROWS_RST = DIM_REG_W'(64);
	localparam logic [DIM_REG_W-1:0] COLS_RST = DIM_REG_W'(64);

	typedef enum logic [MODE_W-1:0] {
		MODE_IDENT  = 3'd0,
		MODE_ROT90  = 3'd1,
		MODE_ROT180 = 3'd2,
		MODE_ROT270 = 3'd3,
		MODE_MIRR   = 3'd4,
		MODE_MIRC   = 3'd5
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE = 2'd0,
		CFG_ROWS = 2'd1,
		CFG_COLS = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_FETCH = 1'b1
	} opcode_t;

	// Coordinates and end mark of one fetched pixel, travelling alongside the read.
	typedef struct packed {
		logic [COORD_W-1:0] out_row;
		logic [COORD_W-1:0] out_col;
		logic               frame_end;
	} fetch_meta_t;

endpackage

@@ sv/frm_in_if.sv @@
// Input channel of the frame rotate / mirror block: opcode and pixel beats.
// Depends on frm_pkg for the field widths.
interface frm_in_if;
	import frm_pkg::*;

	logic             valid;
	logic             ready;
	logic             opcode;
	logic [PIX_W-1:0] pixel;

	modport source (output valid, output opcode, output pixel, input ready);
	modport sink (input valid, input opcode, input pixel, output ready);
endinterface

@@ sv/frm_out_if.sv @@
// Result channel of the frame rotate / mirror block: pixel with coordinates.
// Depends on frm_pkg for the field widths.
interface frm_out_if;
	import frm_pkg::*;

	logic               valid;
	logic               ready;
	logic [PIX_W-1:0]   pixel_out;
	logic [COORD_W-1:0] out_row;
	logic [COORD_W-1:0] out_col;
	logic               frame_end;

	modport source (output valid, output pixel_out, output out_row, output out_col,
		output frame_end, input ready);
	modport sink (input valid, input pixel_out, input out_row, input out_col,
		input frame_end, output ready);
endinterface

@@ sv/frm_store.sv @@
// Frame memory: one write and one registered read, sharing a single address port.
// Depends on frm_pkg for the pixel width.
module frm_store #(
	parameter int MAX_SIDE = frm_pkg::MAX_SIDE_DEF
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic                                        re,
	input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]        addr,
	input  logic [frm_pkg::PIX_W-1:0]                   wdata,
	output logic [frm_pkg::PIX_W-1:0]                   rdata
);
	import frm_pkg::*;

	localparam int DEPTH  = MAX_SIDE * MAX_SIDE;

	logic [PIX_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		// The read register holds its value while no read is issued.
		if (re) begin
			rdata <= mem_q[addr];
		end
	end
endmodule

@@ sv/frm_addr_gen.sv @@
// Configuration registers, load and fetch position counters and the address
// map of each transform. Depends on frm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module frm_addr_gen #(
	parameter int MAX_SIDE = frm_pkg::MAX_SIDE_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [frm_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [frm_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 fire,
	input  logic                                 opcode,
	input  logic [frm_pkg::PIX_W-1:0]            pixel,
	output logic                                 mem_we,
	output logic                                 mem_re,
	output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] mem_addr,
	output logic [frm_pkg::PIX_W-1:0]            mem_wdata,
	output frm_pkg::fetch_meta_t                 meta
);
	import frm_pkg::*;

	localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int POS_W  = $clog2(MAX_SIDE);
	localparam int DIM_W  = $clog2(MAX_SIDE + 1);

	logic [MODE_W-1:0]    mode_q;
	logic [DIM_REG_W-1:0] rows_q, cols_q;
	logic [POS_W-1:0]     load_row_q, load_col_q, emit_row_q, emit_col_q;

	logic [DIM_W-1:0] nr, nc, orows, ocols, src_r, src_c;
	logic [POS_W-1:0] ld_r, ld_c, em_r, em_c;
	logic             rot, ld_wrap, em_wrap;
	logic             ld_last_col, ld_last_row, em_last_col, em_last_row;
	logic             is_load;

	function automatic logic [DIM_W-1:0] clamp_side(input logic [DIM_REG_W-1:0] v);
		if (v == '0) begin
			return DIM_W'(1);
		end
		if (int'(v) > MAX_SIDE) begin
			return DIM_W'(MAX_SIDE);
		end
		return DIM_W'(v);
	endfunction

	function automatic logic [ADDR_W-1:0] addr_of(input logic [POS_W-1:0] r,
		input logic [POS_W-1:0] c);
		return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_SIDE)) + ADDR_W'(c);
	endfunction

	always_comb begin
		nr    = clamp_side(rows_q);
		nc    = clamp_side(cols_q);
		rot   = (mode_q == MODE_ROT90) || (mode_q == MODE_ROT270);
		orows = rot ? nc : nr;
		ocols = rot ? nr : nc;

		// A position left outside shrunken dimensions restarts at the origin.
		ld_wrap = (DIM_W'(load_row_q) >= nr) || (DIM_W'(load_col_q) >= nc);
		ld_r    = ld_wrap ? '0 : load_row_q;
		ld_c    = ld_wrap ? '0 : load_col_q;
		em_wrap = (DIM_W'(emit_row_q) >= orows) || (DIM_W'(emit_col_q) >= ocols);
		em_r    = em_wrap ? '0 : emit_row_q;
		em_c    = em_wrap ? '0 : emit_col_q;

		ld_last_col = (DIM_W'(ld_c) + DIM_W'(1)) >= nc;
		ld_last_row = (DIM_W'(ld_r) + DIM_W'(1)) >= nr;
		em_last_col = (DIM_W'(em_c) + DIM_W'(1)) >= ocols;
		em_last_row = (DIM_W'(em_r) + DIM_W'(1)) >= orows;

		unique case (mode_q)
			MODE_ROT90: begin
				src_r = DIM_W'(em_c);
				src_c = nc - DIM_W'(1) - DIM_W'(em_r);
			end
			MODE_ROT180: begin
				src_r = nr - DIM_W'(1) - DIM_W'(em_r);
				src_c = nc - DIM_W'(1) - DIM_W'(em_c);
			end
			MODE_ROT270: begin
				src_r = nr - DIM_W'(1) - DIM_W'(em_c);
				src_c = DIM_W'(em_r);
			end
			MODE_MIRR: begin
				src_r = nr - DIM_W'(1) - DIM_W'(em_r);
				src_c = DIM_W'(em_c);
			end
			MODE_MIRC: begin
				src_r = DIM_W'(em_r);
				src_c = nc - DIM_W'(1) - DIM_W'(em_c);
			end
			default: begin
				src_r = DIM_W'(em_r);
				src_c = DIM_W'(em_c);
			end
		endcase

		is_load   = (opcode == OP_LOAD);
		mem_we    = fire && is_load;
		mem_re    = fire && !is_load;
		mem_wdata = pixel;
		mem_addr  = is_load ? addr_of(ld_r, ld_c) : addr_of(POS_W'(src_r), POS_W'(src_c));

		meta.out_row   = COORD_W'(em_r);
		meta.out_col   = COORD_W'(em_c);
		meta.frame_end = em_last_row && em_last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDENT;
			rows_q     <= ROWS_RST;
			cols_q     <= COLS_RST;
			load_row_q <= '0;
			load_col_q <= '0;
			emit_row_q <= '0;
			emit_col_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_MODE: mode_q <= MODE_W'(cfg_data);
					CFG_ROWS: rows_q <= DIM_REG_W'(cfg_data);
					CFG_COLS: cols_q <= DIM_REG_W'(cfg_data);
					default: ;
				endcase
			end
			if (mem_we) begin
				if (ld_last_col) begin
					load_col_q <= '0;
					load_row_q <= ld_last_row ? '0 : POS_W'(DIM_W'(ld_r) + DIM_W'(1));
				end else begin
					load_row_q <= ld_r;
					load_col_q <= POS_W'(DIM_W'(ld_c) + DIM_W'(1));
				end
			end
			if (mem_re) begin
				if (em_last_col) begin
					emit_col_q <= '0;
					emit_row_q <= em_last_row ? '0 : POS_W'(DIM_W'(em_r) + DIM_W'(1));
				end else begin
					emit_row_q <= em_r;
					emit_col_q <= POS_W'(DIM_W'(em_c) + DIM_W'(1));
				end
			end
		end
	end

	`ASSERT_NEVER(a_single_access, clk, arst_n, mem_we && mem_re, "write and read issued together")
	`ASSERT_IMPL(a_read_in_frame, clk, arst_n, mem_re, (int'(src_r) < int'(nr)) && (int'(src_c) < int'(nc)), "fetch maps outside the loaded frame")
	`ASSERT_IMPL(a_end_on_last, clk, arst_n, mem_re && meta.frame_end, em_last_row, "frame end away from the last output row")
endmodule

@@ sv/frm_out_stage.sv @@
// Read pipeline stage and output register with its stall control.
// Depends on frm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module frm_out_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           issue,
	input  frm_pkg::fetch_meta_t           meta,
	input  logic [frm_pkg::PIX_W-1:0]      rdata,
	input  logic                           out_ready,
	output logic                           accept_ok,
	output logic                           out_valid,
	output logic [frm_pkg::PIX_W-1:0]      pixel_out,
	output frm_pkg::fetch_meta_t           out_meta
);
	import frm_pkg::*;

	logic        valid_s1;
	fetch_meta_t meta_s1;
	logic        out_valid_q;
	logic [PIX_W-1:0] pixel_q;
	fetch_meta_t meta_q;
	logic        advance;

	// The read stage moves on whenever the output register is free or being emptied.
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign accept_ok = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			meta_s1 <= meta;
		end
		if (advance) begin
			pixel_q <= rdata;
			meta_q  <= meta_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_q;
	assign out_meta  = meta_q;

	`ASSERT_NEXT(a_issue_lands, clk, arst_n, issue, valid_s1, "accepted fetch did not reach the read stage")
	`ASSERT_NEXT(a_stall_holds, clk, arst_n, valid_s1 && out_valid_q && !out_ready, valid_s1 && $stable(meta_s1), "stalled read stage lost its beat")
	`ASSERT_NEXT(a_free_output_fills, clk, arst_n, valid_s1 && !out_valid_q, out_valid_q, "read stage did not move into a free output register")
endmodule

@@ sv/frame_rotate_mirror.sv @@
// Frame rotate / mirror store, top level.
// Load beats (opcode 0) on req write the next pixel of a rows x cols frame in
// raster order, wrapping to the origin after the last pixel. Fetch beats
// (opcode 1) read the next pixel of the transformed frame in its raster order;
// each fetch gives one beat on rsp with the pixel, its output row and column
// and a frame end mark on the last pixel. Rotations by 90 and 270 degrees swap
// the output dimensions. Load beats give no result.
// Every beat costs one access to the single frame memory, so the block takes
// one beat per clock while rsp does not stall. A fetch result passes through
// the memory read register, then the output register, before rsp offers it.
// When rsp stalls, one fetch waits in the read stage and one in the output
// register; req then drops ready until the output register empties.
// The user must write configuration (mode, rows, cols) through cfg_we, cfg_idx
// and cfg_data only while no beats are in flight; the block does not enforce it.
// Reset clears the positions and restores identity mode with a 64 x 64 frame;
// the memory is not cleared, so a frame must be loaded before it is fetched.
module frame_rotate_mirror #(
	parameter int MAX_SIDE = frm_pkg::MAX_SIDE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [frm_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [frm_pkg::CFG_DATA_W-1:0] cfg_data,
	frm_in_if.sink                         req,
	frm_out_if.source                      rsp
);
	import frm_pkg::*;

	localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE);

	logic              fire, accept_ok;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_addr;
	logic [PIX_W-1:0]  mem_wdata, mem_rdata;
	fetch_meta_t       meta, out_meta;

	assign req.ready = accept_ok;
	assign fire      = req.valid && accept_ok;

	frm_addr_gen #(.MAX_SIDE(MAX_SIDE)) u_addr_gen (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.fire     (fire),
		.opcode   (req.opcode),
		.pixel    (req.pixel),
		.mem_we   (mem_we),
		.mem_re   (mem_re),
		.mem_addr (mem_addr),
		.mem_wdata(mem_wdata),
		.meta     (meta)
	);

	frm_store #(.MAX_SIDE(MAX_SIDE)) u_store (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	frm_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.issue    (mem_re),
		.meta     (meta),
		.rdata    (mem_rdata),
		.out_ready(rsp.ready),
		.accept_ok(accept_ok),
		.out_valid(rsp.valid),
		.pixel_out(rsp.pixel_out),
		.out_meta (out_meta)
	);

	assign rsp.out_row   = out_meta.out_row;
	assign rsp.out_col   = out_meta.out_col;
	assign rsp.frame_end = out_meta.frame_end;
endmodule

@@ tb/sv/frame_rotate_mirror_tb.sv @@
// Self-checking testbench for frame_rotate_mirror: loads frames, fetches them back under every
// transform and compares each result beat with a cycle-free prediction kept in this module.
// Depends on frm_pkg, frm_in_if, frm_out_if and the frame_rotate_mirror RTL.
module frame_rotate_mirror_tb;
	import frm_pkg::*;

	localparam int SIDE          = MAX_SIDE_DEF;
	localparam int RANDOM_BEATS  = 1350;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES   = 200;
	localparam int QUIET_LIMIT   = 5000;
	localparam int REPORT_LIMIT  = 100;

	// Mode codes outside the enum; the block treats them as identity.
	localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

	typedef struct packed {
		opcode_t          op;
		logic [PIX_W-1:0] pix;
	} pixel_beat_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pix;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               fend;
	} fetched_pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	frm_in_if  req ();
	frm_out_if rsp ();

	frame_rotate_mirror dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req),
		.rsp      (rsp)
	);

	always #2 clk = ~clk;

	// Predicted block state, advanced as beats are accepted.
	logic [PIX_W-1:0]     frame_img [SIDE*SIDE];
	int unsigned          ld_row = 0, ld_col = 0, em_row = 0, em_col = 0;
	logic [MODE_W-1:0]    cur_mode = MODE_IDENT;
	logic [DIM_REG_W-1:0] cur_rows = ROWS_RST;
	logic [DIM_REG_W-1:0] cur_cols = COLS_RST;
	fetched_pixel_t       pixels_due [$];

	// Stimulus planning: which entries will have been written once the queued beats are in.
	bit                   planned_img [SIDE*SIDE];
	int unsigned          plan_row = 0, plan_col = 0;
	pixel_beat_t          beats_waiting [$];
	int                   planned = 0;

	int                   send_idle_pct = 37;
	int                   recv_idle_pct = 54;
	int                   holds_asked = 0;
	int                   holds_served;
	int                   hold_left;
	int                   fault_count = 0;
	int                   quiet_cycles = 0;
	pixel_beat_t          next_beat;
	fetched_pixel_t       due;

	function automatic int unsigned side_of(logic [DIM_REG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > SIDE)
			return SIDE;
		return int'(v);
	endfunction

	function automatic void advance(inout int unsigned r, inout int unsigned c,
		input int unsigned h, input int unsigned w);
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
	endfunction

	function automatic void transform_beat(logic op, logic [PIX_W-1:0] pix);
		int unsigned    nr, nc, oh, ow, sr, sc;
		fetched_pixel_t res;
		nr = side_of(cur_rows);
		nc = side_of(cur_cols);
		if (op == OP_LOAD) begin
			if (ld_row >= nr || ld_col >= nc) begin
				ld_row = 0;
				ld_col = 0;
			end
			frame_img[ld_row*SIDE + ld_col] = pix;
			advance(ld_row, ld_col, nr, nc);
			return;
		end
		if (cur_mode == MODE_ROT90 || cur_mode == MODE_ROT270) begin
			oh = nc;
			ow = nr;
		end else begin
			oh = nr;
			ow = nc;
		end
		if (em_row >= oh || em_col >= ow) begin
			em_row = 0;
			em_col = 0;
		end
		case (cur_mode)
			MODE_ROT90: begin
				sr = em_col;
				sc = nc - 1 - em_row;
			end
			MODE_ROT180: begin
				sr = nr - 1 - em_row;
				sc = nc - 1 - em_col;
			end
			MODE_ROT270: begin
				sr = nr - 1 - em_col;
				sc = em_row;
			end
			MODE_MIRR: begin
				sr = nr - 1 - em_row;
				sc = em_col;
			end
			MODE_MIRC: begin
				sr = em_row;
				sc = nc - 1 - em_col;
			end
			default: begin
				sr = em_row;
				sc = em_col;
			end
		endcase
		res.pix  = frame_img[sr*SIDE + sc];
		res.row  = COORD_W'(em_row);
		res.col  = COORD_W'(em_col);
		res.fend = (em_row == oh - 1) && (em_col == ow - 1);
		pixels_due.push_back(res);
		advance(em_row, em_col, oh, ow);
	endfunction

	function automatic void plan_beat(opcode_t op, logic [PIX_W-1:0] pix);
		pixel_beat_t b;
		int unsigned nr, nc;
		b.op  = op;
		b.pix = pix;
		if (op == OP_LOAD) begin
			nr = side_of(cur_rows);
			nc = side_of(cur_cols);
			if (plan_row >= nr || plan_col >= nc) begin
				plan_row = 0;
				plan_col = 0;
			end
			planned_img[plan_row*SIDE + plan_col] = 1'b1;
			advance(plan_row, plan_col, nr, nc);
		end
		beats_waiting.push_back(b);
		planned++;
	endfunction

	// A fetch is legal only once every entry of the active frame has been written.
	function automatic bit frame_covered();
		int unsigned nr, nc;
		nr = side_of(cur_rows);
		nc = side_of(cur_cols);
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++)
				if (!planned_img[r*SIDE + c])
					return 1'b0;
		return 1'b1;
	endfunction

	// Returns once nothing is queued or in flight, after letting trailing loads settle.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (beats_waiting.size() != 0 || req.valid || pixels_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_MODE: cur_mode = val[MODE_W-1:0];
			CFG_ROWS: cur_rows = val;
			CFG_COLS: cur_cols = val;
			default: ;
		endcase
	endtask

	task automatic configure(logic [MODE_W-1:0] m, logic [DIM_REG_W-1:0] r,
		logic [DIM_REG_W-1:0] c, bit wm, bit wr, bit wc);
		wait_idle();
		if (wm)
			write_reg(CFG_MODE, CFG_DATA_W'(m));
		if (wr)
			write_reg(CFG_ROWS, r);
		if (wc)
			write_reg(CFG_COLS, c);
		cfg_we <= 1'b0;
	endtask

	task automatic fetch_run(logic [MODE_W-1:0] m, int n);
		configure(m, '0, '0, 1'b1, 1'b0, 1'b0);
		repeat (n) plan_beat(OP_FETCH, PIX_W'($urandom_range(255)));
	endtask

	// Sender: offers queued beats, idling at random whenever the channel is free.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid  <= 1'b0;
			req.opcode <= OP_LOAD;
			req.pixel  <= '0;
		end else begin
			if (req.valid && req.ready)
				transform_beat(req.opcode, req.pixel);
			if (!req.valid || req.ready) begin
				if (beats_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_beat = beats_waiting.pop_front();
					req.valid  <= 1'b1;
					req.opcode <= next_beat.op;
					req.pixel  <= next_beat.pix;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result beat and drives ready, with long hold-offs on request.
	// Results are printed as pixel/row/col/end.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready    <= 1'b0;
			hold_left    <= 0;
			holds_served <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pixels_due.size() == 0) begin
					if (fault_count < REPORT_LIMIT)
						$display("%0t: unexpected result, expected none, got %02h/%0d/%0d/%0b",
							$time, rsp.pixel_out, rsp.out_row, rsp.out_col, rsp.frame_end);
					fault_count++;
				end else begin
					due = pixels_due.pop_front();
					if (due.pix !== rsp.pixel_out || due.row !== rsp.out_row ||
						due.col !== rsp.out_col || due.fend !== rsp.frame_end) begin
						if (fault_count < REPORT_LIMIT)
							$display("%0t: mismatch, expected %02h/%0d/%0d/%0b, got %02h/%0d/%0d/%0b",
								$time, due.pix, due.row, due.col, due.fend,
								rsp.pixel_out, rsp.out_row, rsp.out_col, rsp.frame_end);
						fault_count++;
					end
				end
			end
			if (holds_served != holds_asked) begin
				holds_served <= holds_asked;
				hold_left    <= HOLD_CYCLES;
				rsp.ready    <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int                   phase_no;
		int                   k, beats, half;
		bit                   well_formed, pause_mid;
		logic [MODE_W-1:0]    m;
		logic [DIM_REG_W-1:0] r, c;

		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_idx    = CFG_MODE;
		cfg_data   = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A 2 x 3 frame of extreme values, then read back under every mode in turn,
		// leaving all but the first read-out part way so that the next mode picks up mid-frame.
		configure(MODE_IDENT, 7'd2, 7'd3, 1'b1, 1'b1, 1'b1);
		plan_beat(OP_LOAD, 8'h00);
		plan_beat(OP_LOAD, 8'hFF);
		plan_beat(OP_LOAD, 8'h01);
		plan_beat(OP_LOAD, 8'h80);
		plan_beat(OP_LOAD, 8'h7F);
		plan_beat(OP_LOAD, 8'hFE);
		fetch_run(MODE_ROT90, 6);
		fetch_run(MODE_ROT180, 3);
		fetch_run(MODE_ROT270, 3);
		fetch_run(MODE_MIRR, 2);
		fetch_run(MODE_MIRC, 2);
		fetch_run(MODE_SPARE6, 1);
		fetch_run(MODE_SPARE7, 1);
		fetch_run(MODE_IDENT, 1);

		phase_no = 0;
		planned  = 0;
		while (planned < RANDOM_BEATS) begin
			if (planned >= 2 * RANDOM_BEATS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (planned >= RANDOM_BEATS / 3) begin
				send_idle_pct = 54;
				recv_idle_pct = 37;
			end

			// The first phases pin the side extremes, including out-of-range register values.
			case (phase_no)
				0: begin
					r = 7'd64;
					c = 7'd1;
				end
				1: begin
					r = 7'd1;
					c = 7'd127;
				end
				2: begin
					r = 7'($urandom_range(126, 65));
					c = 7'd2;
				end
				3: begin
					r = 7'd0;
					c = 7'd5;
				end
				4: begin
					r = 7'd3;
					c = 7'd0;
				end
				default: begin
					k = $urandom_range(99);
					if (k < 85) begin
						r = 7'($urandom_range(8, 1));
						c = 7'($urandom_range(8, 1));
					end else if (k < 92) begin
						r = 7'($urandom_range(64, 9));
						c = 7'($urandom_range(3, 1));
					end else begin
						r = 7'($urandom_range(3, 1));
						c = 7'($urandom_range(64, 9));
					end
				end
			endcase
			m = MODE_W'($urandom_range(7));
			configure(m, r, c, phase_no < 5 || $urandom_range(99) < 70,
				phase_no < 5 || $urandom_range(99) < 70,
				phase_no < 5 || $urandom_range(99) < 70);

			well_formed = phase_no < 5 || $urandom_range(99) < 70;
			if (well_formed) begin
				beats = side_of(cur_rows) * side_of(cur_cols);
				repeat (beats) plan_beat(OP_LOAD, PIX_W'($urandom_range(255)));
				// A long receiver hold-off lets fetches pile up behind a full pipeline.
				if (phase_no % 8 == 0)
					holds_asked++;
				if ($urandom_range(4) == 0)
					beats = 2 * beats;
				pause_mid = phase_no == 6 || $urandom_range(99) < 15;
				half = beats / 2;
				for (int i = 0; i < beats; i++) begin
					if (pause_mid && i == half)
						wait_idle();
					plan_beat(OP_FETCH, PIX_W'($urandom_range(255)));
				end
			end else begin
				// Broken sequences: partial loads and fetches interleaved at random.
				repeat ($urandom_range(24, 1)) begin
					if ($urandom_range(1) == 1 && frame_covered())
						plan_beat(OP_FETCH, PIX_W'($urandom_range(255)));
					else
						plan_beat(OP_LOAD, PIX_W'($urandom_range(255)));
				end
			end
			phase_no++;
		end

		wait_idle();
		if (fault_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
